FILE: hdl/qvr_pkg.sv
// ----------------------------------------------------------------------------
// Quaternion vector rotation package
// Shared widths, defaults and types for the quaternion rotation pipeline.
// ----------------------------------------------------------------------------
package qvr_pkg;

    // Quaternion components are fixed 16-bit signed values.
    localparam int QUAT_W = 16;

    // Default fraction bits of the quaternion and default vector width.
    localparam int QUAT_FRAC_BITS_DEF = 14;
    localparam int VEC_WIDTH_DEF      = 24;

    // Width of one quaternion component product.
    localparam int PQ_W = 2 * QUAT_W;

    // A rotation matrix coefficient is a sum of products, doubled; two
    // extra bits hold it exactly.
    localparam int COEF_W = PQ_W + 2;

    // Three vector axes and a 3x3 coefficient matrix, stored row-major.
    localparam int NUM_AXES = 3;
    localparam int NUM_COEF = NUM_AXES * NUM_AXES;

    typedef struct packed {
        logic signed [QUAT_W-1:0] x;
        logic signed [QUAT_W-1:0] y;
        logic signed [QUAT_W-1:0] z;
        logic signed [QUAT_W-1:0] w;
    } quat_t;

    // All ten distinct pairwise component products.
    typedef struct packed {
        logic signed [PQ_W-1:0] xx;
        logic signed [PQ_W-1:0] yy;
        logic signed [PQ_W-1:0] zz;
        logic signed [PQ_W-1:0] ww;
        logic signed [PQ_W-1:0] xy;
        logic signed [PQ_W-1:0] xz;
        logic signed [PQ_W-1:0] yz;
        logic signed [PQ_W-1:0] wx;
        logic signed [PQ_W-1:0] wy;
        logic signed [PQ_W-1:0] wz;
    } quat_prod_t;

    typedef logic signed [COEF_W-1:0] coef_t;

endpackage

FILE: hdl/qvr_item_if.sv
// ----------------------------------------------------------------------------
// Quaternion rotation input channel
// Valid/ready channel carrying one quaternion and one vector per transaction.
// ----------------------------------------------------------------------------
interface qvr_item_if #(
    parameter int VEC_WIDTH = qvr_pkg::VEC_WIDTH_DEF
);

    logic                              valid;
    logic                              ready;
    logic signed [qvr_pkg::QUAT_W-1:0] quat_x;
    logic signed [qvr_pkg::QUAT_W-1:0] quat_y;
    logic signed [qvr_pkg::QUAT_W-1:0] quat_z;
    logic signed [qvr_pkg::QUAT_W-1:0] quat_w;
    logic signed [VEC_WIDTH-1:0]       vec_x;
    logic signed [VEC_WIDTH-1:0]       vec_y;
    logic signed [VEC_WIDTH-1:0]       vec_z;

    modport source (
        output valid,
        input  ready,
        output quat_x,
        output quat_y,
        output quat_z,
        output quat_w,
        output vec_x,
        output vec_y,
        output vec_z
    );

    modport sink (
        input  valid,
        output ready,
        input  quat_x,
        input  quat_y,
        input  quat_z,
        input  quat_w,
        input  vec_x,
        input  vec_y,
        input  vec_z
    );

endinterface

FILE: hdl/qvr_result_if.sv
// ----------------------------------------------------------------------------
// Quaternion rotation result channel
// Valid/ready channel carrying one rotated vector and its overflow flag.
// ----------------------------------------------------------------------------
interface qvr_result_if #(
    parameter int VEC_WIDTH = qvr_pkg::VEC_WIDTH_DEF
);

    logic                        valid;
    logic                        ready;
    logic signed [VEC_WIDTH-1:0] rot_x;
    logic signed [VEC_WIDTH-1:0] rot_y;
    logic signed [VEC_WIDTH-1:0] rot_z;
    logic                        overflow;

    modport source (
        output valid,
        input  ready,
        output rot_x,
        output rot_y,
        output rot_z,
        output overflow
    );

    modport sink (
        input  valid,
        output ready,
        input  rot_x,
        input  rot_y,
        input  rot_z,
        input  overflow
    );

endinterface

FILE: hdl/qvr_coef.sv
// ----------------------------------------------------------------------------
// Rotation matrix coefficient stages
// Two pipeline stages: quaternion component products, then the nine
// coefficients of the equivalent rotation matrix. The vector rides along.
// ----------------------------------------------------------------------------
module qvr_coef #(
    parameter int VEC_WIDTH = qvr_pkg::VEC_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        up_valid,
    output logic                        up_ready,
    input  qvr_pkg::quat_t              quat,
    input  logic signed [VEC_WIDTH-1:0] vec [qvr_pkg::NUM_AXES],

    output logic                        dn_valid,
    input  logic                        dn_ready,
    output qvr_pkg::coef_t              coef [qvr_pkg::NUM_COEF],
    output logic signed [VEC_WIDTH-1:0] vec_dn [qvr_pkg::NUM_AXES]
);

    localparam int PQ_W     = qvr_pkg::PQ_W;
    localparam int COEF_W   = qvr_pkg::COEF_W;
    localparam int NUM_AXES = qvr_pkg::NUM_AXES;
    localparam int NUM_COEF = qvr_pkg::NUM_COEF;

    logic                        s1_valid_reg;
    logic                        s2_valid_reg;
    logic                        s1_en;
    logic                        s2_en;

    qvr_pkg::quat_prod_t         prod_reg;
    qvr_pkg::quat_prod_t         prod_next;
    logic signed [VEC_WIDTH-1:0] s1_vec_reg [NUM_AXES];

    qvr_pkg::coef_t              coef_reg  [NUM_COEF];
    qvr_pkg::coef_t              coef_next [NUM_COEF];
    logic signed [VEC_WIDTH-1:0] s2_vec_reg [NUM_AXES];

    // A stage advances when it is empty or its successor takes its content.
    assign s2_en    = !s2_valid_reg || dn_ready;
    assign s1_en    = !s1_valid_reg || s2_en;
    assign up_ready = s1_en;

    // Stage 1: the ten pairwise products of the quaternion components.
    always_comb
    begin
        prod_next.xx = PQ_W'(quat.x) * PQ_W'(quat.x);
        prod_next.yy = PQ_W'(quat.y) * PQ_W'(quat.y);
        prod_next.zz = PQ_W'(quat.z) * PQ_W'(quat.z);
        prod_next.ww = PQ_W'(quat.w) * PQ_W'(quat.w);
        prod_next.xy = PQ_W'(quat.x) * PQ_W'(quat.y);
        prod_next.xz = PQ_W'(quat.x) * PQ_W'(quat.z);
        prod_next.yz = PQ_W'(quat.y) * PQ_W'(quat.z);
        prod_next.wx = PQ_W'(quat.w) * PQ_W'(quat.x);
        prod_next.wy = PQ_W'(quat.w) * PQ_W'(quat.y);
        prod_next.wz = PQ_W'(quat.w) * PQ_W'(quat.z);
    end

    // Stage 2: the rotation matrix, exact, without any scaling.
    always_comb
    begin
        qvr_pkg::coef_t xx;
        qvr_pkg::coef_t yy;
        qvr_pkg::coef_t zz;
        qvr_pkg::coef_t ww;
        qvr_pkg::coef_t xy;
        qvr_pkg::coef_t xz;
        qvr_pkg::coef_t yz;
        qvr_pkg::coef_t wx;
        qvr_pkg::coef_t wy;
        qvr_pkg::coef_t wz;
        xx = COEF_W'(prod_reg.xx);
        yy = COEF_W'(prod_reg.yy);
        zz = COEF_W'(prod_reg.zz);
        ww = COEF_W'(prod_reg.ww);
        xy = COEF_W'(prod_reg.xy);
        xz = COEF_W'(prod_reg.xz);
        yz = COEF_W'(prod_reg.yz);
        wx = COEF_W'(prod_reg.wx);
        wy = COEF_W'(prod_reg.wy);
        wz = COEF_W'(prod_reg.wz);
        coef_next[0] = ww + xx - yy - zz;
        coef_next[1] = (xy - wz) <<< 1;
        coef_next[2] = (xz + wy) <<< 1;
        coef_next[3] = (xy + wz) <<< 1;
        coef_next[4] = ww - xx + yy - zz;
        coef_next[5] = (yz - wx) <<< 1;
        coef_next[6] = (xz - wy) <<< 1;
        coef_next[7] = (yz + wx) <<< 1;
        coef_next[8] = ww - xx - yy + zz;
    end

    // Valid bits of both stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_en)
            begin
                s1_valid_reg <= up_valid;
            end
            if (s2_en)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Payload of both stages, loaded only with a valid transaction.
    always_ff @(posedge clk)
    begin
        if (s1_en && up_valid)
        begin
            prod_reg   <= prod_next;
            s1_vec_reg <= vec;
        end
        if (s2_en && s1_valid_reg)
        begin
            coef_reg   <= coef_next;
            s2_vec_reg <= s1_vec_reg;
        end
    end

    assign dn_valid = s2_valid_reg;
    assign coef     = coef_reg;
    assign vec_dn   = s2_vec_reg;

endmodule

FILE: hdl/qvr_mac.sv
// ----------------------------------------------------------------------------
// Matrix-vector multiply-accumulate stages
// Three pipeline stages: coefficient times vector half-word partial products,
// full products, then per-axis sums with the rounding offset added.
// ----------------------------------------------------------------------------
module qvr_mac #(
    parameter int VEC_WIDTH      = qvr_pkg::VEC_WIDTH_DEF,
    parameter int QUAT_FRAC_BITS = qvr_pkg::QUAT_FRAC_BITS_DEF,
    parameter int SUM_W          = qvr_pkg::COEF_W + VEC_WIDTH + 3
) (
    input  logic                    clk,
    input  logic                    rst_n,

    input  logic                    up_valid,
    output logic                    up_ready,
    input  qvr_pkg::coef_t          coef [qvr_pkg::NUM_COEF],
    input  logic signed [VEC_WIDTH-1:0] vec [qvr_pkg::NUM_AXES],

    output logic                    dn_valid,
    input  logic                    dn_ready,
    output logic signed [SUM_W-1:0] sum [qvr_pkg::NUM_AXES]
);

    localparam int COEF_W   = qvr_pkg::COEF_W;
    localparam int NUM_AXES = qvr_pkg::NUM_AXES;
    localparam int NUM_COEF = qvr_pkg::NUM_COEF;

    // The vector is split into an unsigned low half and a signed high half.
    localparam int LO_W = VEC_WIDTH / 2;
    localparam int HI_W = VEC_WIDTH - LO_W;
    localparam int PL_W = COEF_W + LO_W + 1;
    localparam int PH_W = COEF_W + HI_W;
    localparam int P_W  = COEF_W + VEC_WIDTH;

    // Adding one half of the result LSB makes the later shift round half up.
    localparam logic signed [SUM_W-1:0] HALF =
        {{(SUM_W-1){1'b0}}, 1'b1} << (2 * QUAT_FRAC_BITS - 1);

    logic                    s3_valid_reg;
    logic                    s4_valid_reg;
    logic                    s5_valid_reg;
    logic                    s3_en;
    logic                    s4_en;
    logic                    s5_en;

    logic signed [LO_W:0]    vec_lo [NUM_AXES];
    logic signed [HI_W-1:0]  vec_hi [NUM_AXES];

    logic signed [PL_W-1:0]  pl_reg  [NUM_COEF];
    logic signed [PL_W-1:0]  pl_next [NUM_COEF];
    logic signed [PH_W-1:0]  ph_reg  [NUM_COEF];
    logic signed [PH_W-1:0]  ph_next [NUM_COEF];
    logic signed [P_W-1:0]   p_reg   [NUM_COEF];
    logic signed [P_W-1:0]   p_next  [NUM_COEF];
    logic signed [SUM_W-1:0] sum_reg  [NUM_AXES];
    logic signed [SUM_W-1:0] sum_next [NUM_AXES];

    // Stage handshake chain.
    assign s5_en    = !s5_valid_reg || dn_ready;
    assign s4_en    = !s4_valid_reg || s5_en;
    assign s3_en    = !s3_valid_reg || s4_en;
    assign up_ready = s3_en;

    // Vector halves.
    always_comb
    begin
        for (int c = 0; c < NUM_AXES; c++)
        begin
            vec_lo[c] = {1'b0, vec[c][LO_W-1:0]};
            vec_hi[c] = vec[c][VEC_WIDTH-1:LO_W];
        end
    end

    // Stage 3: eighteen partial products, each coefficient by both halves.
    always_comb
    begin
        for (int r = 0; r < NUM_AXES; r++)
        begin
            for (int c = 0; c < NUM_AXES; c++)
            begin
                pl_next[r*NUM_AXES+c] = PL_W'(coef[r*NUM_AXES+c]) * PL_W'(vec_lo[c]);
                ph_next[r*NUM_AXES+c] = PH_W'(coef[r*NUM_AXES+c]) * PH_W'(vec_hi[c]);
            end
        end
    end

    // Stage 4: recombine the halves into the nine full products.
    always_comb
    begin
        for (int k = 0; k < NUM_COEF; k++)
        begin
            p_next[k] = (P_W'(ph_reg[k]) <<< LO_W) + P_W'(pl_reg[k]);
        end
    end

    // Stage 5: one dot product per output axis, plus the rounding offset.
    always_comb
    begin
        for (int r = 0; r < NUM_AXES; r++)
        begin
            sum_next[r] = SUM_W'(p_reg[r*NUM_AXES])
                        + SUM_W'(p_reg[r*NUM_AXES+1])
                        + SUM_W'(p_reg[r*NUM_AXES+2])
                        + HALF;
        end
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            if (s3_en)
            begin
                s3_valid_reg <= up_valid;
            end
            if (s4_en)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
            if (s5_en)
            begin
                s5_valid_reg <= s4_valid_reg;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (s3_en && up_valid)
        begin
            pl_reg <= pl_next;
            ph_reg <= ph_next;
        end
        if (s4_en && s3_valid_reg)
        begin
            p_reg <= p_next;
        end
        if (s5_en && s4_valid_reg)
        begin
            sum_reg <= sum_next;
        end
    end

    assign dn_valid = s5_valid_reg;
    assign sum      = sum_reg;

endmodule

FILE: hdl/qvr_sat.sv
// ----------------------------------------------------------------------------
// Rounding shift and saturation stage
// Drops the quaternion fraction bits, clamps each axis to the vector width,
// and holds the result in the output register until it is taken.
// ----------------------------------------------------------------------------
module qvr_sat #(
    parameter int VEC_WIDTH      = qvr_pkg::VEC_WIDTH_DEF,
    parameter int QUAT_FRAC_BITS = qvr_pkg::QUAT_FRAC_BITS_DEF,
    parameter int SUM_W          = qvr_pkg::COEF_W + VEC_WIDTH + 3
) (
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        up_valid,
    output logic                        up_ready,
    input  logic signed [SUM_W-1:0]     sum [qvr_pkg::NUM_AXES],

    output logic                        dn_valid,
    input  logic                        dn_ready,
    output logic signed [VEC_WIDTH-1:0] rot [qvr_pkg::NUM_AXES],
    output logic                        overflow
);

    localparam int NUM_AXES = qvr_pkg::NUM_AXES;

    localparam logic signed [SUM_W-1:0] ONE   = {{(SUM_W-1){1'b0}}, 1'b1};
    localparam logic signed [SUM_W-1:0] MAX_V = (ONE <<< (VEC_WIDTH - 1)) - ONE;
    localparam logic signed [SUM_W-1:0] MIN_V = -(ONE <<< (VEC_WIDTH - 1));

    logic                        s6_valid_reg;
    logic                        s6_en;
    logic signed [VEC_WIDTH-1:0] rot_reg  [NUM_AXES];
    logic signed [VEC_WIDTH-1:0] rot_next [NUM_AXES];
    logic                        ovf_reg;
    logic                        ovf_next;

    assign s6_en    = !s6_valid_reg || dn_ready;
    assign up_ready = s6_en;

    // Shift out the fraction bits, then clamp to the signed output range.
    always_comb
    begin
        logic signed [SUM_W-1:0] sh;
        ovf_next = 1'b0;
        for (int r = 0; r < NUM_AXES; r++)
        begin
            sh = sum[r] >>> (2 * QUAT_FRAC_BITS);
            if (sh > MAX_V)
            begin
                rot_next[r] = MAX_V[VEC_WIDTH-1:0];
                ovf_next    = 1'b1;
            end
            else if (sh < MIN_V)
            begin
                rot_next[r] = MIN_V[VEC_WIDTH-1:0];
                ovf_next    = 1'b1;
            end
            else
            begin
                rot_next[r] = sh[VEC_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s6_valid_reg <= 1'b0;
        end
        else if (s6_en)
        begin
            s6_valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s6_en && up_valid)
        begin
            rot_reg <= rot_next;
            ovf_reg <= ovf_next;
        end
    end

    assign dn_valid = s6_valid_reg;
    assign rot      = rot_reg;
    assign overflow = ovf_reg;

endmodule

FILE: hdl/quaternion_vector_rotate.sv
// ----------------------------------------------------------------------------
// Quaternion vector rotation
// Rotates a fixed-point 3-vector by a Q2.14 quaternion, with rounding and
// saturation of the result.
// ----------------------------------------------------------------------------
// The block takes one quaternion and vector per clock while the output
// is not held off; a transaction may enter every cycle, because each of
// the six register stages (component products, matrix coefficients,
// half-word partial products, full products, per-axis sums, rounding
// and saturation) has its own multipliers or adders. The input
// is not normalized, so a non-unit quaternion also scales the vector by
// its squared norm. Results are rounded half up and clamped to the vector
// width, and overflow reports that any axis was clamped. When the output
// is held off, the stages fill up behind it and ready falls only once the
// pipeline is full; no transaction is lost or repeated.
// ----------------------------------------------------------------------------
module quaternion_vector_rotate #(
    parameter int QUAT_FRAC_BITS = qvr_pkg::QUAT_FRAC_BITS_DEF,
    parameter int VEC_WIDTH      = qvr_pkg::VEC_WIDTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    qvr_item_if.sink      item,
    qvr_result_if.source  result
);

    localparam int NUM_AXES = qvr_pkg::NUM_AXES;
    localparam int NUM_COEF = qvr_pkg::NUM_COEF;
    localparam int ACC_W    = qvr_pkg::COEF_W + VEC_WIDTH + 2;
    localparam int SUM_W    =
        ((ACC_W > 2 * QUAT_FRAC_BITS) ? ACC_W : (2 * QUAT_FRAC_BITS + 1)) + 1;

    qvr_pkg::quat_t              quat_in;
    logic signed [VEC_WIDTH-1:0] vec_in [NUM_AXES];

    logic                        coef_valid;
    logic                        coef_ready;
    qvr_pkg::coef_t              coef [NUM_COEF];
    logic signed [VEC_WIDTH-1:0] coef_vec [NUM_AXES];

    logic                        sum_valid;
    logic                        sum_ready;
    logic signed [SUM_W-1:0]     sum [NUM_AXES];

    logic signed [VEC_WIDTH-1:0] rot [NUM_AXES];

    // Gather the input transaction fields.
    always_comb
    begin
        quat_in.x = item.quat_x;
        quat_in.y = item.quat_y;
        quat_in.z = item.quat_z;
        quat_in.w = item.quat_w;
        vec_in[0] = item.vec_x;
        vec_in[1] = item.vec_y;
        vec_in[2] = item.vec_z;
    end

    qvr_coef #(
        .VEC_WIDTH (VEC_WIDTH)
    ) u_coef (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (item.valid),
        .up_ready (item.ready),
        .quat     (quat_in),
        .vec      (vec_in),
        .dn_valid (coef_valid),
        .dn_ready (coef_ready),
        .coef     (coef),
        .vec_dn   (coef_vec)
    );

    qvr_mac #(
        .VEC_WIDTH      (VEC_WIDTH),
        .QUAT_FRAC_BITS (QUAT_FRAC_BITS),
        .SUM_W          (SUM_W)
    ) u_mac (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (coef_valid),
        .up_ready (coef_ready),
        .coef     (coef),
        .vec      (coef_vec),
        .dn_valid (sum_valid),
        .dn_ready (sum_ready),
        .sum      (sum)
    );

    qvr_sat #(
        .VEC_WIDTH      (VEC_WIDTH),
        .QUAT_FRAC_BITS (QUAT_FRAC_BITS),
        .SUM_W          (SUM_W)
    ) u_sat (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (sum_valid),
        .up_ready (sum_ready),
        .sum      (sum),
        .dn_valid (result.valid),
        .dn_ready (result.ready),
        .rot      (rot),
        .overflow (result.overflow)
    );

    // Scatter the result transaction fields.
    assign result.rot_x = rot[0];
    assign result.rot_y = rot[1];
    assign result.rot_z = rot[2];

endmodule

FILE: sim/quaternion_vector_rotate_test.sv
// ----------------------------------------------------------------------------
// Quaternion vector rotation testbench
// Drives rotations into the pipeline over its valid/ready channels, predicts
// each rotated vector with exact integer arithmetic (rounded half up and
// saturated), and checks every result in order, under several pacing modes.
// ----------------------------------------------------------------------------
module quaternion_vector_rotate_test;

    localparam int FRAC     = qvr_pkg::QUAT_FRAC_BITS_DEF;
    localparam int VW       = qvr_pkg::VEC_WIDTH_DEF;
    localparam int QW       = qvr_pkg::QUAT_W;
    localparam int LATENCY  = 6;
    localparam int WATCHDOG = 2000;

    localparam longint AXIS_MAX = (longint'(1) <<< (VW - 1)) - 1;
    localparam longint AXIS_MIN = -(longint'(1) <<< (VW - 1));
    localparam longint ROUND_HALF = longint'(1) <<< (2 * FRAC - 1);

    typedef struct packed {
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic signed [VW-1:0] z;
    } vec3_t;

    typedef struct {
        logic signed [VW-1:0] rot_x;
        logic signed [VW-1:0] rot_y;
        logic signed [VW-1:0] rot_z;
        logic                 overflow;
    } rotation_t;

    logic clk = 1'b0;
    logic rst_n;

    qvr_item_if   #(.VEC_WIDTH(VW)) item_ch ();
    qvr_result_if #(.VEC_WIDTH(VW)) result_ch ();

    quaternion_vector_rotate #(
        .QUAT_FRAC_BITS(FRAC),
        .VEC_WIDTH     (VW)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item_ch),
        .result(result_ch)
    );

    rotation_t pending_rotations[$];
    int        send_idle_pct;
    int        stall_pct;
    int        rotations_sent = 0;
    int        results_checked = 0;
    int        saturated_results = 0;
    int        mismatches = 0;
    int        quiet_cycles = 0;

    // Clock with a period of 10.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Exact rotation: r = M(q) * v, shifted by 2*FRAC, rounded half up, saturated.
    function automatic rotation_t rotate_vector(input qvr_pkg::quat_t q, input vec3_t v);
        longint    x, y, z, w, s, acc;
        longint    m[3][3];
        longint    vin[3];
        rotation_t r;
        logic signed [VW-1:0] axis[3];
        x = q.x;
        y = q.y;
        z = q.z;
        w = q.w;
        vin[0] = v.x;
        vin[1] = v.y;
        vin[2] = v.z;
        s = w * w - x * x - y * y - z * z;
        m[0][0] = s + 2 * x * x;
        m[0][1] = 2 * (x * y - w * z);
        m[0][2] = 2 * (x * z + w * y);
        m[1][0] = 2 * (x * y + w * z);
        m[1][1] = s + 2 * y * y;
        m[1][2] = 2 * (y * z - w * x);
        m[2][0] = 2 * (x * z - w * y);
        m[2][1] = 2 * (y * z + w * x);
        m[2][2] = s + 2 * z * z;
        r.overflow = 1'b0;
        for (int a = 0; a < 3; a++)
        begin
            acc = m[a][0] * vin[0] + m[a][1] * vin[1] + m[a][2] * vin[2];
            acc = (acc + ROUND_HALF) >>> (2 * FRAC);
            if (acc > AXIS_MAX)
            begin
                acc = AXIS_MAX;
                r.overflow = 1'b1;
            end
            else if (acc < AXIS_MIN)
            begin
                acc = AXIS_MIN;
                r.overflow = 1'b1;
            end
            axis[a] = acc[VW-1:0];
        end
        r.rot_x = axis[0];
        r.rot_y = axis[1];
        r.rot_z = axis[2];
        return r;
    endfunction

    function automatic qvr_pkg::quat_t make_quat(input int x, input int y, input int z,
                                                 input int w);
        qvr_pkg::quat_t q;
        q.x = x[QW-1:0];
        q.y = y[QW-1:0];
        q.z = z[QW-1:0];
        q.w = w[QW-1:0];
        return q;
    endfunction

    function automatic vec3_t make_vec(input int x, input int y, input int z);
        vec3_t v;
        v.x = x[VW-1:0];
        v.y = y[VW-1:0];
        v.z = z[VW-1:0];
        return v;
    endfunction

    // Signed value drawn uniformly from [-span, span].
    function automatic int signed_draw(input int span);
        return int'($urandom_range(2 * span)) - span;
    endfunction

    // Random unit quaternion in Q2.14, normalized through real arithmetic.
    function automatic qvr_pkg::quat_t random_unit_quat();
        real a, b, c, d, n;
        a = real'(signed_draw(16384));
        b = real'(signed_draw(16384));
        c = real'(signed_draw(16384));
        d = real'(signed_draw(16384));
        n = $sqrt(a * a + b * b + c * c + d * d);
        if (n < 1.0)
            return make_quat(0, 0, 0, 16384);
        return make_quat(int'(a * 16384.0 / n), int'(b * 16384.0 / n),
                         int'(c * 16384.0 / n), int'(d * 16384.0 / n));
    endfunction

    // Full-range axis value, often shifted down to reach small magnitudes.
    function automatic logic signed [VW-1:0] random_axis();
        logic signed [VW-1:0] a;
        a = VW'($urandom);
        if ($urandom_range(1) == 0)
            a = a >>> $urandom_range(VW - 1);
        return a;
    endfunction

    // Present one transaction and hold it until the block takes it.
    task automatic send_rotation(input qvr_pkg::quat_t q, input vec3_t v);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid  <= 1'b1;
        item_ch.quat_x <= q.x;
        item_ch.quat_y <= q.y;
        item_ch.quat_z <= q.z;
        item_ch.quat_w <= q.w;
        item_ch.vec_x  <= v.x;
        item_ch.vec_y  <= v.y;
        item_ch.vec_z  <= v.z;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
    endtask

    task automatic check_field(input string field, input longint want, input longint got);
        if (want != got)
        begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
            mismatches++;
        end
    endtask

    // Track accepted inputs and check each result against the oldest prediction.
    always @(posedge clk)
    begin : track_block
        qvr_pkg::quat_t q;
        vec3_t          v;
        rotation_t      want;
        if (rst_n && item_ch.valid && item_ch.ready)
        begin
            q.x = item_ch.quat_x;
            q.y = item_ch.quat_y;
            q.z = item_ch.quat_z;
            q.w = item_ch.quat_w;
            v.x = item_ch.vec_x;
            v.y = item_ch.vec_y;
            v.z = item_ch.vec_z;
            pending_rotations.push_back(rotate_vector(q, v));
            rotations_sent++;
        end
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_rotations.size() == 0)
            begin
                $display("%0t: result with no rotation pending: x %0d y %0d z %0d ovf %0b",
                         $time, result_ch.rot_x, result_ch.rot_y, result_ch.rot_z,
                         result_ch.overflow);
                mismatches++;
            end
            else
            begin
                want = pending_rotations.pop_front();
                check_field("rot_x", want.rot_x, result_ch.rot_x);
                check_field("rot_y", want.rot_y, result_ch.rot_y);
                check_field("rot_z", want.rot_z, result_ch.rot_z);
                check_field("overflow", want.overflow, result_ch.overflow);
                results_checked++;
                if (result_ch.overflow)
                    saturated_results++;
            end
        end
    end

    // Receiver back-pressure.
    always @(posedge clk)
        result_ch.ready <= rst_n && ($urandom_range(99) >= stall_pct);

    // Watchdog on cycles in which neither channel moves a transaction.
    always @(posedge clk)
    begin
        if (!rst_n || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG)
        begin
            $display("%0t: no transaction for %0d cycles", $time, WATCHDOG);
            $display("tb: failure");
            $finish;
        end
    end

    // Identity, zero and quarter/half turns about the axes.
    task automatic test_basic_rotations();
        send_rotation(make_quat(0, 0, 0, 16384), make_vec(8388607, -8388608, 1));
        send_rotation(make_quat(0, 0, 0, 16384), make_vec(0, 0, 0));
        send_rotation(make_quat(0, 0, 11585, 11585), make_vec(1000000, 0, -7));
        send_rotation(make_quat(0, 11585, 0, -11585), make_vec(12345, -54321, 4000000));
        send_rotation(make_quat(0, 16384, 0, 0), make_vec(-3000000, 77, 3000000));
        send_rotation(make_quat(0, 0, 0, 0), make_vec(8388607, 8388607, -8388608));
    endtask

    // Quaternion fields at their extremes, some alone and some together.
    task automatic test_field_extremes();
        send_rotation(make_quat(-32768, -32768, -32768, -32768),
                      make_vec(8388607, -8388608, 8388607));
        send_rotation(make_quat(32767, 32767, 32767, 32767), make_vec(-1, 1, -1));
        send_rotation(make_quat(-32768, 0, 0, 0), make_vec(1, -1, 2097151));
        send_rotation(make_quat(0, 32767, 0, 0), make_vec(100, 200, 300));
        send_rotation(make_quat(0, 0, -32768, 32767), make_vec(-8388608, 0, 8388607));
    endtask

    // Exact halves round toward plus infinity.
    task automatic test_rounding_ties();
        send_rotation(make_quat(0, 0, 0, 128), make_vec(8192, -8192, 24576));
        send_rotation(make_quat(0, 0, 0, -128), make_vec(-24576, 40960, -40960));
        send_rotation(make_quat(0, 0, 0, 128), make_vec(8191, -8193, 1));
    endtask

    // Clamping at both limits, and values landing exactly on a limit.
    task automatic test_saturation();
        send_rotation(make_quat(16384, 0, 0, 0), make_vec(1, -8388608, 8388607));
        send_rotation(make_quat(0, 0, 0, -32768), make_vec(2097151, -2097152, 0));
        send_rotation(make_quat(0, 0, 0, -32768), make_vec(2097152, -2097153, 5));
        send_rotation(make_quat(0, 0, 0, 32767), make_vec(2097152, -2097152, 2097151));
    endtask

    // Mostly unit rotations, some near-unit and some arbitrary quaternions.
    task automatic test_random_rotations(input int count, input int idle, input int stall);
        qvr_pkg::quat_t q;
        vec3_t          v;
        int             pick;
        send_idle_pct = idle;
        stall_pct     = stall;
        repeat (count)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
                q = random_unit_quat();
            else if (pick < 80)
            begin
                q = random_unit_quat();
                q.x = q.x + QW'(signed_draw(64));
                q.w = q.w + QW'(signed_draw(64));
            end
            else
                q = {$urandom, $urandom};
            v.x = random_axis();
            v.y = random_axis();
            v.z = random_axis();
            send_rotation(q, v);
        end
    endtask

    // Let the pipeline drain, then report.
    task automatic finish_run();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_rotations.size() != 0)
            @(posedge clk);
        repeat (4 * LATENCY)
            @(posedge clk);
        $display("Covered %0d rotations: directed extremes, ties and clamping, then random",
                 rotations_sent);
        $display("unit and raw quaternions under four pacing modes; %0d checked, %0d saturated.",
                 results_checked, saturated_results);
        if (mismatches == 0 && pending_rotations.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    endtask

    initial
    begin
        rst_n             <= 1'b0;
        item_ch.valid     <= 1'b0;
        item_ch.quat_x    <= '0;
        item_ch.quat_y    <= '0;
        item_ch.quat_z    <= '0;
        item_ch.quat_w    <= '0;
        item_ch.vec_x     <= '0;
        item_ch.vec_y     <= '0;
        item_ch.vec_z     <= '0;
        send_idle_pct     = 0;
        stall_pct         = 0;
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_rotations();
        test_field_extremes();
        test_rounding_ties();
        test_saturation();
        test_random_rotations(490, 0, 0);
        test_random_rotations(490, 61, 0);
        test_random_rotations(490, 0, 61);
        test_random_rotations(490, 25, 25);
        finish_run();
    end

endmodule

FILE: files.f
hdl/qvr_pkg.sv
hdl/qvr_item_if.sv
hdl/qvr_result_if.sv
hdl/qvr_coef.sv
hdl/qvr_mac.sv
hdl/qvr_sat.sv
hdl/quaternion_vector_rotate.sv
sim/quaternion_vector_rotate_test.sv
